// ===== sv/swam_pkg.sv =====
`default_nettype none

package swam_pkg;

   localparam int SymbolWidth   = 8;
   localparam int NumSymbols    = 256;
   localparam int CountWidth    = 9;
   localparam int PositionWidth = 32;
   localparam int OpWidth       = 2;

   typedef enum logic [OpWidth-1:0] {
      OP_CLEAR   = 2'd0,
      OP_PATTERN = 2'd1,
      OP_TEXT    = 2'd2
   } op_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } engine_state_type;

   // One symbol in flight through the balance read-modify-write pipeline.
   typedef struct packed {
      logic                     valid;
      logic                     write;
      logic                     up;
      logic                     retire;
      logic                     check;
      logic [SymbolWidth-1:0]   symbol;
      logic [PositionWidth-1:0] position;
   } stage_type;

endpackage

`default_nettype wire

// ===== sv/sliding_window_anagram_matcher.sv =====
`default_nettype none

// Reports each text position where the next pattern-length text symbols are a
// permutation of the loaded pattern. A beat on req_ carries an operation in
// req_tuser (clear, pattern symbol, text symbol) and a byte symbol in req_tdata;
// a match returns the window's zero-based start index on rsp_. A pattern or text
// beat is not taken while the previous one is in stage A: a text symbol in a
// full window needs two read-modify-writes of the 256-entry balance memory (the
// incoming and the retiring symbol) through its single write port. A match passes
// through stage A, stage B and the result queue before it appears on rsp_. After
// reset, and after every clear beat, a clearing pass writes all 256 entries of the
// balance memory one entry per cycle, during which req_tready stays low.
module sliding_window_anagram_matcher
   import swam_pkg::*;
#(
   parameter int MAX_PATTERN = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [7:0]               req_tdata,   // [7:0] symbol
   input  wire logic [OpWidth-1:0]       req_tuser,   // [1:0] operation
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [PositionWidth-1:0] rsp_tdata    // [31:0] match_position
);

   localparam int LenWidth = $clog2(MAX_PATTERN + 1);
   localparam int IdxWidth = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int BalWidth = LenWidth + 1;
   localparam logic [LenWidth-1:0] MaxLen = LenWidth'(MAX_PATTERN);

   engine_state_type state_ff, state_in;
   logic [SymbolWidth-1:0]   sweep_ff, sweep_in;
   logic [LenWidth-1:0]      plen_ff, plen_in;
   logic [LenWidth-1:0]      fill_ff, fill_in;
   logic [IdxWidth-1:0]      head_ff, head_in;
   logic [PositionWidth-1:0] pos_ff, pos_in;
   logic                     started_ff, started_in;
   logic [CountWidth-1:0]    count_ff, count_in;
   stage_type                sa_ff, sa_in;
   stage_type                sb_ff, sb_in;
   logic                     lw_valid_ff;
   logic [SymbolWidth-1:0]   lw_addr_ff;
   logic [BalWidth-1:0]      lw_data_ff;

   logic                   accept;
   op_type                 op;
   logic                   filling;
   logic [LenWidth-1:0]    head_inc;
   logic                   wram_we;
   logic [IdxWidth-1:0]    wram_addr;
   logic [SymbolWidth-1:0] wram_rdata;
   logic                   bram_we;
   logic [SymbolWidth-1:0] bram_waddr;
   logic [BalWidth-1:0]    bram_wdata;
   logic [BalWidth-1:0]    bram_rdata_a;
   logic [BalWidth-1:0]    bram_rdata_b;
   logic [BalWidth-1:0]    bal_a, bal_a_new;
   logic [BalWidth-1:0]    bal_b, bal_b_new;
   logic                   sa_rmw, sb_rmw;
   logic [CountWidth-1:0]  count_sb;
   logic                   match;
   logic [1:0]             q_level;
   logic [1:0]             q_after;
   logic                   pop;

   assign accept   = req_tvalid && req_tready;
   assign op       = op_type'(req_tuser);
   assign filling  = (fill_ff < plen_ff);
   assign head_inc = LenWidth'(head_ff) + LenWidth'(1);
   assign pop      = rsp_tvalid && rsp_tready;
   assign q_after  = q_level - {1'b0, pop};

   // One slot of the result queue is held for the symbol that may still match.
   assign req_tready = (state_ff == ST_RUN) && !sa_ff.valid
                       && (({1'b0, q_after} + {2'b0, sb_ff.valid}) < 3'd2);

   // Issue: window bookkeeping is settled when the beat is taken.
   always_comb begin
      state_in   = state_ff;
      sweep_in   = sweep_ff;
      plen_in    = plen_ff;
      fill_in    = fill_ff;
      head_in    = head_ff;
      pos_in     = pos_ff;
      started_in = started_ff;
      sa_in      = '0;
      wram_we    = 1'b0;
      wram_addr  = filling ? fill_ff[IdxWidth-1:0] : head_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            sweep_in = sweep_ff + SymbolWidth'(1);
            if (sweep_ff == SymbolWidth'(NumSymbols - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (accept) begin
               sa_in.valid  = (op != OP_CLEAR);
               sa_in.symbol = req_tdata;
               sa_in.position = pos_ff - PositionWidth'(plen_ff) + PositionWidth'(1);
               unique case (op)
                  OP_CLEAR: begin
                     state_in   = ST_CLEAR;
                     sweep_in   = '0;
                     plen_in    = '0;
                     fill_in    = '0;
                     head_in    = '0;
                     pos_in     = '0;
                     started_in = 1'b0;
                  end
                  OP_PATTERN: begin
                     if (!started_ff && (plen_ff < MaxLen)) begin
                        sa_in.write = 1'b1;
                        sa_in.up    = 1'b1;
                        plen_in     = plen_ff + LenWidth'(1);
                     end
                  end
                  OP_TEXT: begin
                     started_in = 1'b1;
                     pos_in     = pos_ff + PositionWidth'(1);
                     if (plen_ff != '0) begin
                        sa_in.write = 1'b1;
                        wram_we     = 1'b1;
                        if (filling) begin
                           fill_in     = fill_ff + LenWidth'(1);
                           head_in     = '0;
                           sa_in.check = ((fill_ff + LenWidth'(1)) == plen_ff);
                        end else begin
                           sa_in.retire = 1'b1;
                           sa_in.check  = 1'b1;
                           head_in = (head_inc >= plen_ff) ? '0 : head_inc[IdxWidth-1:0];
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Stage A applies the incoming symbol; stage B retires the oldest one.
   always_comb begin
      sb_in        = sa_ff;
      sb_in.symbol = wram_rdata;
      sb_in.write  = sa_ff.retire;
      sb_in.up     = 1'b1;

      bal_a     = (lw_valid_ff && (lw_addr_ff == sa_ff.symbol)) ? lw_data_ff : bram_rdata_a;
      bal_a_new = sa_ff.up ? bal_a + BalWidth'(1) : bal_a - BalWidth'(1);
      bal_b     = (lw_valid_ff && (lw_addr_ff == sb_ff.symbol)) ? lw_data_ff : bram_rdata_b;
      bal_b_new = bal_b + BalWidth'(1);

      sa_rmw = sa_ff.valid && sa_ff.write;
      sb_rmw = sb_ff.valid && sb_ff.write;

      count_sb = count_ff;
      if (sb_rmw) begin
         if (bal_b == '0) begin
            count_sb = count_ff + CountWidth'(1);
         end else if (bal_b_new == '0) begin
            count_sb = count_ff - CountWidth'(1);
         end
      end
      count_in = count_sb;
      if (sa_rmw) begin
         if (bal_a == '0) begin
            count_in = count_sb + CountWidth'(1);
         end else if (bal_a_new == '0) begin
            count_in = count_sb - CountWidth'(1);
         end
      end
      if (state_ff == ST_RUN && accept && op == OP_CLEAR) begin
         count_in = '0;
      end

      match = sb_ff.valid && sb_ff.check && (count_sb == '0);

      priority if (state_ff == ST_CLEAR) begin
         bram_we    = 1'b1;
         bram_waddr = sweep_ff;
         bram_wdata = '0;
      end else if (sa_rmw) begin
         bram_we    = 1'b1;
         bram_waddr = sa_ff.symbol;
         bram_wdata = bal_a_new;
      end else begin
         bram_we    = sb_rmw;
         bram_waddr = sb_ff.symbol;
         bram_wdata = bal_b_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         sweep_ff    <= '0;
         plen_ff     <= '0;
         fill_ff     <= '0;
         head_ff     <= '0;
         pos_ff      <= '0;
         started_ff  <= 1'b0;
         count_ff    <= '0;
         sa_ff       <= '0;
         sb_ff       <= '0;
         lw_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sweep_ff    <= sweep_in;
         plen_ff     <= plen_in;
         fill_ff     <= fill_in;
         head_ff     <= head_in;
         pos_ff      <= pos_in;
         started_ff  <= started_in;
         count_ff    <= count_in;
         sa_ff       <= sa_in;
         sb_ff       <= sb_in;
         lw_valid_ff <= bram_we;
      end
   end

   // The last write is kept to bypass a read that was issued in the same cycle.
   always_ff @(posedge clock) begin
      lw_addr_ff <= bram_waddr;
      lw_data_ff <= bram_wdata;
   end

   swam_window_ram #(
      .Depth     (MAX_PATTERN),
      .AddrWidth (IdxWidth)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (wram_we),
      .addr    (wram_addr),
      .wr_data (req_tdata),
      .rd_data (wram_rdata)
   );

   swam_balance_ram #(
      .DataWidth (BalWidth)
   ) u_balance_ram (
      .clock     (clock),
      .wr_en     (bram_we),
      .wr_addr   (bram_waddr),
      .wr_data   (bram_wdata),
      .rd_addr_a (req_tdata),
      .rd_addr_b (wram_rdata),
      .rd_data_a (bram_rdata_a),
      .rd_data_b (bram_rdata_b)
   );

   swam_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (match),
      .push_data  (sb_ff.position),
      .level      (q_level),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(sa_rmw && sb_rmw))
      else $error("balance memory written by both stages in one cycle");

   a_issue_spacing: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("symbol taken while the previous one is in stage A");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (q_level == 2'd2 && !pop) |-> !match)
      else $error("match pushed into a full result queue");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= plen_ff)
      else $error("window fill exceeds pattern length");

endmodule

`default_nettype wire

// ===== sv/swam_balance_ram.sv =====
`default_nettype none

module swam_balance_ram
   import swam_pkg::*;
#(
   parameter int DataWidth = 6
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [SymbolWidth-1:0] wr_addr,
   input  wire logic [DataWidth-1:0]   wr_data,
   input  wire logic [SymbolWidth-1:0] rd_addr_a,
   input  wire logic [SymbolWidth-1:0] rd_addr_b,
   output logic      [DataWidth-1:0]   rd_data_a,
   output logic      [DataWidth-1:0]   rd_data_b
);

   logic [DataWidth-1:0] mem [NumSymbols];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

// ===== sv/swam_window_ram.sv =====
`default_nettype none

module swam_window_ram
   import swam_pkg::*;
#(
   parameter int Depth     = 16,
   parameter int AddrWidth = 4
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [AddrWidth-1:0]   addr,
   input  wire logic [SymbolWidth-1:0] wr_data,
   output logic      [SymbolWidth-1:0] rd_data
);

   logic [SymbolWidth-1:0] mem [Depth];

   // Read-first: a retiring symbol is read from the slot that the new one overwrites.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

`default_nettype wire

// ===== sv/swam_rsp_queue.sv =====
`default_nettype none

module swam_rsp_queue
   import swam_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire logic [PositionWidth-1:0] push_data,
   output logic      [1:0]               level,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [PositionWidth-1:0] rsp_tdata
);

   logic [PositionWidth-1:0] entry_ff [2];
   logic                     wr_ptr_ff;
   logic                     wr_ptr_in;
   logic                     rd_ptr_ff;
   logic                     rd_ptr_in;
   logic [1:0]               level_ff;
   logic [1:0]               level_in;
   logic                     pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (level_ff != 2'd0);
   assign rsp_tdata  = entry_ff[rd_ptr_ff];
   assign level      = level_ff;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== verif/tb_sliding_window_anagram_matcher.sv =====
`default_nettype none

module tb_sliding_window_anagram_matcher;
   import swam_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxPattern = 16;
   localparam logic [OpWidth-1:0] OpUnused = 2'd3;
   localparam int PhaseItems = 425;
   localparam int HoldoffCycles = 600;
   localparam int WatchdogLimit = 4000;
   localparam int MaxReports = 10;

   typedef struct packed {
      logic [OpWidth-1:0]     op;
      logic [SymbolWidth-1:0] symbol;
   } stream_beat_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = '0;    // [7:0] symbol
   logic [OpWidth-1:0]       req_tuser = '0;    // [1:0] operation
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [PositionWidth-1:0] rsp_tdata;         // [31:0] match_position

   sliding_window_anagram_matcher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stimulus and pacing.
   stream_beat_type beat_queue[$];
   int              queued_count = 0;
   int              accepted_count = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   bit              want_holdoff = 1'b0;
   bit              holdoff_used = 1'b0;
   int              holdoff_left = 0;
   logic            req_fire = 1'b0;

   // Predictor state.
   int                       sym_balance[0:NumSymbols-1];
   int                       unbalanced;
   logic [SymbolWidth-1:0]   win_buf[0:MaxPattern-1];
   int                       win_head;
   int                       win_fill;
   int                       pat_len;
   logic [PositionWidth-1:0] text_pos;
   bit                       text_seen;
   logic [PositionWidth-1:0] expected_matches[$];

   int mismatches = 0;
   int idle_cycles = 0;

   function automatic void queue_beat(logic [OpWidth-1:0] op, logic [SymbolWidth-1:0] s);
      stream_beat_type b;
      b.op = op;
      b.symbol = s;
      beat_queue.push_back(b);
      queued_count++;
   endfunction

   function automatic void clear_matcher();
      for (int i = 0; i < NumSymbols; i++) sym_balance[i] = 0;
      unbalanced = 0;
      win_head = 0;
      win_fill = 0;
      pat_len = 0;
      text_pos = '0;
      text_seen = 1'b0;
   endfunction

   function automatic void shift_balance(logic [SymbolWidth-1:0] s, int delta);
      int old_bal;
      old_bal = sym_balance[s];
      sym_balance[s] = old_bal + delta;
      if (old_bal == 0 && sym_balance[s] != 0) begin
         unbalanced++;
      end else if (old_bal != 0 && sym_balance[s] == 0) begin
         unbalanced--;
      end
   endfunction

   function automatic void track_beat(logic [OpWidth-1:0] op, logic [SymbolWidth-1:0] s);
      logic [PositionWidth-1:0] here;
      case (op)
         OP_CLEAR: begin
            clear_matcher();
         end
         OP_PATTERN: begin
            if (!text_seen && pat_len < MaxPattern) begin
               shift_balance(s, 1);
               pat_len++;
            end
         end
         OP_TEXT: begin
            text_seen = 1'b1;
            here = text_pos;
            text_pos = text_pos + 1;
            if (pat_len != 0) begin
               shift_balance(s, -1);
               if (win_fill < pat_len) begin
                  win_buf[win_fill] = s;
                  win_fill++;
                  win_head = 0;
               end else begin
                  // The oldest window symbol leaves and its slot takes the new one.
                  shift_balance(win_buf[win_head], 1);
                  win_buf[win_head] = s;
                  win_head++;
                  if (win_head >= pat_len) win_head = 0;
               end
               if (win_fill == pat_len && unbalanced == 0) begin
                  expected_matches.push_back(here - PositionWidth'(pat_len - 1));
               end
            end
         end
         default: ;
      endcase
   endfunction

   // One search run: usually a clear, a pattern over a small alphabet, then text
   // built mostly from shuffled copies of the pattern so that matches are common.
   task automatic queue_search_run();
      logic [SymbolWidth-1:0] alphabet[4];
      logic [SymbolWidth-1:0] pat[$];
      logic [SymbolWidth-1:0] perm[$];
      logic [SymbolWidth-1:0] t;
      int n_alpha, plen, n_text, done, r, j, k;
      n_alpha = $urandom_range(1, 4);
      for (j = 0; j < 4; j++) alphabet[j] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 11) != 0) queue_beat(OP_CLEAR, 8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 5) begin
         plen = 0;
      end else if (r < 15) begin
         plen = $urandom_range(MaxPattern - 2, MaxPattern + 4);
      end else begin
         plen = $urandom_range(1, 6);
      end
      for (j = 0; j < plen; j++) begin
         t = alphabet[$urandom_range(0, n_alpha - 1)];
         queue_beat(OP_PATTERN, t);
         if (j < MaxPattern) pat.push_back(t);
      end
      n_text = $urandom_range(8, 40);
      done = 0;
      while (done < n_text) begin
         r = $urandom_range(0, 99);
         if (r < 45 && pat.size() != 0) begin
            perm = pat;
            for (j = perm.size() - 1; j > 0; j--) begin
               k = $urandom_range(0, j);
               t = perm[j];
               perm[j] = perm[k];
               perm[k] = t;
            end
            foreach (perm[i]) queue_beat(OP_TEXT, perm[i]);
            done += perm.size();
         end else if (r < 85) begin
            queue_beat(OP_TEXT, alphabet[$urandom_range(0, n_alpha - 1)]);
            done++;
         end else if (r < 92) begin
            queue_beat(OP_TEXT, 8'($urandom_range(0, 255)));
            done++;
         end else if (r < 96) begin
            queue_beat(OpUnused, 8'($urandom_range(0, 255)));
         end else begin
            queue_beat(OP_PATTERN, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || expected_matches.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Driver: a beat stays on the bus until it is taken.
   always @(negedge clock) begin
      stream_beat_type beat;
      if (!reset && (!req_tvalid || req_fire)) begin
         if (beat_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            beat = beat_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= beat.symbol;
            req_tuser <= beat.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver side, including the one long hold-off.
   always @(negedge clock) begin
      if (want_holdoff && !holdoff_used) begin
         holdoff_left = HoldoffCycles;
         holdoff_used = 1'b1;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Monitor: checks each result beat, then predicts from each accepted input beat.
   always @(posedge clock) begin
      logic [PositionWidth-1:0] want;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_matches.size() == 0) begin
               mismatches++;
               if (mismatches <= MaxReports) begin
                  $display("unexpected match beat: match_position=%0d", rsp_tdata);
               end
            end else begin
               want = expected_matches.pop_front();
               if (rsp_tdata !== want) begin
                  mismatches++;
                  if (mismatches <= MaxReports) begin
                     $display("match_position mismatch: expected %0d, got %0d",
                              want, rsp_tdata);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            track_beat(req_tuser, req_tdata);
            accepted_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WatchdogLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      int ph;
      int phase_start;
      clear_matcher();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed: unused code, empty pattern, late pattern symbols, short text,
      // extreme symbols and overlapping matches.
      queue_beat(OpUnused, 8'hFF);
      queue_beat(OP_TEXT, 8'h00);
      queue_beat(OP_TEXT, 8'hFF);
      queue_beat(OP_PATTERN, 8'h00);
      queue_beat(OP_CLEAR, 8'hFF);
      queue_beat(OP_PATTERN, 8'h00);
      queue_beat(OP_PATTERN, 8'hFF);
      queue_beat(OP_PATTERN, 8'h00);
      queue_beat(OP_TEXT, 8'hFF);
      queue_beat(OP_TEXT, 8'h00);
      queue_beat(OP_TEXT, 8'h00);
      queue_beat(OP_TEXT, 8'hFF);
      queue_beat(OP_TEXT, 8'h55);
      queue_beat(OP_PATTERN, 8'h55);
      queue_beat(OpUnused, 8'h00);
      queue_beat(OP_TEXT, 8'h00);
      queue_beat(OP_TEXT, 8'hFF);
      queue_beat(OP_TEXT, 8'h00);
      queue_beat(OP_CLEAR, 8'hAA);
      queue_beat(OP_TEXT, 8'h12);

      for (ph = 0; ph < 4; ph++) begin
         wait_drained();
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         phase_start = queued_count;
         if (ph == 0) begin
            // A one-symbol pattern matches on every text beat; with the receiver
            // held off this backs the block up until it stops taking input.
            want_holdoff = 1'b1;
            queue_beat(OP_CLEAR, 8'h00);
            queue_beat(OP_PATTERN, 8'h41);
            repeat (60) queue_beat(OP_TEXT, 8'h41);
         end
         while (queued_count - phase_start < PhaseItems) queue_search_run();
      end

      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && expected_matches.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
